[src/alarm_match_beep_controller_assert.svh]
// Assertion macros shared by the alarm controller RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ALARM_MATCH_BEEP_CONTROLLER_ASSERT_SVH
`define ALARM_MATCH_BEEP_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define AMBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define AMBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ambc_pkg.sv]
`default_nettype none

package ambc_pkg;

	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int MS_W        = 32;
	localparam int BEEP_W      = 16;
	localparam int HOUR_W      = 5;
	localparam int MIN_W       = 6;
	localparam int SEC_W       = 6;

	localparam logic [MS_W-1:0]   RING_MAX_RESET = 32'd60000;
	localparam logic [BEEP_W-1:0] BEEP_RESET     = 16'd500;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ALARM_ENABLE = 3'd0,
		REG_ALARM_HOUR   = 3'd1,
		REG_ALARM_MINUTE = 3'd2,
		REG_ALARM_SECOND = 3'd3,
		REG_RING_MAX_MS  = 3'd4,
		REG_BEEP_ON_MS   = 3'd5,
		REG_BEEP_OFF_MS  = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		OP_EVALUATE = 1'b0,
		OP_STOP     = 1'b1
	} op_t;

endpackage

`default_nettype wire

[src/alarm_match_beep_controller.sv]
`default_nettype none
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ----------------------------------------------
// in        sink       in_valid / in_stall    operation hour minute second now_ms
//                                             night_quiet silence_match
// out       source     out_valid / out_stall  buzzer_on ringing silenced
// cfg       sink       cfg_we                 cfg_index cfg_data
//
// Each transaction is held in the input register and produces its result in the output
// register when it leaves, and one transaction is taken every cycle while in_stall is low.
// The alarm state is updated in the same edge that loads the result.
// Reset (arst_n low) clears the state and loads the register defaults at once.
// When out_stall holds a waiting result, one more transaction is still taken into the
// input register; in_stall rises only when both registers are full.

`include "alarm_match_beep_controller_assert.svh"

module alarm_match_beep_controller (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Input transactions.
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 operation,
	input  wire logic [ambc_pkg::HOUR_W-1:0]          hour,
	input  wire logic [ambc_pkg::MIN_W-1:0]           minute,
	input  wire logic [ambc_pkg::SEC_W-1:0]           second,
	input  wire logic [ambc_pkg::MS_W-1:0]            now_ms,
	input  wire logic                                 night_quiet,
	input  wire logic                                 silence_match,
	// Result transactions.
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      buzzer_on,
	output logic                                      ringing,
	output logic                                      silenced,
	// Configuration writes.
	input  wire logic                                 cfg_we,
	input  wire logic [ambc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [ambc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Configuration registers.
	logic                            alarm_enable_q;
	logic [ambc_pkg::HOUR_W-1:0]     alarm_hour_q;
	logic [ambc_pkg::MIN_W-1:0]      alarm_minute_q;
	logic [ambc_pkg::SEC_W-1:0]      alarm_second_q;
	logic [ambc_pkg::MS_W-1:0]       ring_max_q;
	logic [ambc_pkg::BEEP_W-1:0]     beep_on_q;
	logic [ambc_pkg::BEEP_W-1:0]     beep_off_q;

	// Input register.
	logic                            valid_s1;
	ambc_pkg::op_t                   op_s1;
	logic [ambc_pkg::HOUR_W-1:0]     hour_s1;
	logic [ambc_pkg::MIN_W-1:0]      minute_s1;
	logic [ambc_pkg::SEC_W-1:0]      second_s1;
	logic [ambc_pkg::MS_W-1:0]       now_s1;
	logic                            night_s1;
	logic                            silence_s1;

	// Alarm state.
	logic                            ring_q;
	logic                            sil_q;
	logic                            tone_q;
	logic [ambc_pkg::MS_W-1:0]       ring_start_q;
	logic [ambc_pkg::MS_W-1:0]       phase_start_q;

	// Result register.
	logic                            out_valid_q;
	logic                            buzzer_q;
	logic                            ringing_q;
	logic                            silenced_q;

	// Next state.
	logic                            ring_d;
	logic                            sil_d;
	logic                            tone_d;
	logic [ambc_pkg::MS_W-1:0]       ring_start_d;
	logic [ambc_pkg::MS_W-1:0]       phase_start_d;

	logic                            advance;
	logic                            fire_s1;
	logic                            accept;
	logic                            hit;
	logic                            start;
	logic [ambc_pkg::MS_W-1:0]       ring_base;
	logic [ambc_pkg::MS_W-1:0]       phase_base;
	logic [ambc_pkg::MS_W-1:0]       ring_elapsed;
	logic [ambc_pkg::MS_W-1:0]       phase_elapsed;

	// The pipeline moves whenever the result register is empty or being drained.
	assign advance   = !out_valid_q || !out_stall;
	assign fire_s1   = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign buzzer_on = buzzer_q;
	assign ringing   = ringing_q;
	assign silenced  = silenced_q;

	// Configuration writes. Unused indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_enable_q <= 1'b0;
			alarm_hour_q   <= '0;
			alarm_minute_q <= '0;
			alarm_second_q <= '0;
			ring_max_q     <= ambc_pkg::RING_MAX_RESET;
			beep_on_q      <= ambc_pkg::BEEP_RESET;
			beep_off_q     <= ambc_pkg::BEEP_RESET;
		end else if (cfg_we) begin
			case (ambc_pkg::cfg_reg_t'(cfg_index))
				ambc_pkg::REG_ALARM_ENABLE: alarm_enable_q <= cfg_data[0];
				ambc_pkg::REG_ALARM_HOUR:   alarm_hour_q   <= cfg_data[ambc_pkg::HOUR_W-1:0];
				ambc_pkg::REG_ALARM_MINUTE: alarm_minute_q <= cfg_data[ambc_pkg::MIN_W-1:0];
				ambc_pkg::REG_ALARM_SECOND: alarm_second_q <= cfg_data[ambc_pkg::SEC_W-1:0];
				ambc_pkg::REG_RING_MAX_MS:  ring_max_q     <= cfg_data[ambc_pkg::MS_W-1:0];
				ambc_pkg::REG_BEEP_ON_MS:   beep_on_q      <= cfg_data[ambc_pkg::BEEP_W-1:0];
				ambc_pkg::REG_BEEP_OFF_MS:  beep_off_q     <= cfg_data[ambc_pkg::BEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload; it holds while the stage is stalled.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= ambc_pkg::op_t'(operation);
			hour_s1    <= hour;
			minute_s1  <= minute;
			second_s1  <= second;
			now_s1     <= now_ms;
			night_s1   <= night_quiet;
			silence_s1 <= silence_match;
		end
	end

	// A match compares the raw field bits against the alarm registers.
	assign hit = alarm_enable_q && (hour_s1 == alarm_hour_q) &&
		(minute_s1 == alarm_minute_q) && (second_s1 == alarm_second_q);

	// A fresh ring takes the current timestamp as both time marks.
	assign start      = (op_s1 == ambc_pkg::OP_EVALUATE) && hit && !ring_q && !sil_q;
	assign ring_base  = start ? now_s1 : ring_start_q;
	assign phase_base = start ? now_s1 : phase_start_q;

	// Elapsed times wrap modulo 2^32 together with the timestamp.
	assign ring_elapsed  = now_s1 - ring_base;
	assign phase_elapsed = now_s1 - phase_base;

	always_comb begin
		ring_d        = ring_q;
		sil_d         = sil_q;
		tone_d        = tone_q;
		ring_start_d  = ring_start_q;
		phase_start_d = phase_start_q;
		case (op_s1)
			ambc_pkg::OP_STOP: begin
				// A stop ends ringing and may also silence the match.
				ring_d        = 1'b0;
				tone_d        = 1'b0;
				ring_start_d  = '0;
				phase_start_d = '0;
				sil_d         = sil_q || silence_s1;
			end
			ambc_pkg::OP_EVALUATE: begin
				if (start) begin
					ring_d        = 1'b1;
					ring_start_d  = now_s1;
					phase_start_d = now_s1;
					tone_d        = !night_s1;
				end
				// Leaving the matching second clears the silence mark.
				if (!hit) begin
					sil_d = 1'b0;
				end
				if (ring_d) begin
					if (ring_elapsed >= ring_max_q) begin
						// Maximum ring time reached: stop and silence this match.
						ring_d        = 1'b0;
						tone_d        = 1'b0;
						ring_start_d  = '0;
						phase_start_d = '0;
						sil_d         = 1'b1;
					end else if (night_s1) begin
						tone_d = 1'b0;
					end else if (!tone_d) begin
						if (phase_elapsed >= {{(ambc_pkg::MS_W-ambc_pkg::BEEP_W){1'b0}},
							beep_off_q}) begin
							tone_d        = 1'b1;
							phase_start_d = now_s1;
						end
					end else if (phase_elapsed >= {{(ambc_pkg::MS_W-ambc_pkg::BEEP_W){1'b0}},
						beep_on_q}) begin
						tone_d        = 1'b0;
						phase_start_d = now_s1;
					end
				end
			end
			default: ;
		endcase
	end

	// Alarm state advances exactly when a transaction leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q        <= 1'b0;
			sil_q         <= 1'b0;
			tone_q        <= 1'b0;
			ring_start_q  <= '0;
			phase_start_q <= '0;
		end else if (fire_s1) begin
			ring_q        <= ring_d;
			sil_q         <= sil_d;
			tone_q        <= tone_d;
			ring_start_q  <= ring_start_d;
			phase_start_q <= phase_start_d;
		end
	end

	// Result register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result payload reflects the state after the transaction.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			buzzer_q   <= tone_d;
			ringing_q  <= ring_d;
			silenced_q <= sil_d;
		end
	end

	// The buzzer only sounds inside a ringing period.
	`AMBC_ASSERT_NOW(a_tone_needs_ring, tone_q, ring_q, "buzzer active while not ringing")
	// A match cannot be ringing and silenced at the same time.
	`AMBC_ASSERT_NOW(a_ring_not_silenced, ring_q, !sil_q, "ringing while match silenced")
	// A waiting result always mirrors the current alarm state.
	`AMBC_ASSERT_NOW(a_result_tracks_state, out_valid_q,
		(buzzer_q == tone_q) && (ringing_q == ring_q) && (silenced_q == sil_q),
		"result disagrees with alarm state")
	// A stop transaction always ends ringing.
	`AMBC_ASSERT_NEXT(a_stop_ends_ring, fire_s1 && (op_s1 == ambc_pkg::OP_STOP),
		!ring_q && !tone_q, "stop did not end ringing")

endmodule

`default_nettype wire
